/* sv/hdrm_pkg.sv */
// Package for the three-exposure HDR merge unit.
// Holds widths, register indexes, shared types and the ROM builders.
// No dependencies.
package hdrm_pkg;

  localparam int FRACTION_BITS  = 16;
  localparam int LOG_TABLE_BITS = 10;
  localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int WT_W      = 7;
  localparam int DEN_W     = 9;
  localparam int PROD_W    = 15;
  localparam int NUM_W     = 48;
  localparam int DIV_SHIFT = 32 - FRACTION_BITS;
  localparam int QUO_W     = NUM_W - DIV_SHIFT;
  localparam int DIV_STEP  = 4;
  localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W     = DIV_STAGES * DIV_STEP;
  localparam int POS_W     = $clog2(QUO_W);
  localparam int LOG_W     = 16;
  localparam int EXP_W     = 17;
  localparam int LG_W      = $clog2(QUO_W + FRACTION_BITS) + 18;
  localparam int T_W       = LG_W + CFG_W + 1;
  localparam int N_W       = T_W - 28;
  localparam int SH_W      = 6;
  localparam int SH_MAX    = 63;
  localparam int IDX_W     = LOG_TABLE_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA     = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     CFG_RESET     = CFG_W'(4096);

  localparam longint unsigned LN2_Q30 = 64'd744261118;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_W-1:0] cfg_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  typedef logic [LOG_W-1:0] log_rom_t [TABLE_SIZE];
  typedef logic [EXP_W-1:0] exp_rom_t [TABLE_SIZE];

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    longint unsigned m;
    int unsigned acc;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      m = longint'(TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
      acc = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        acc = acc << 1;
        if (m >= (64'd2 << 30)) begin
          acc = acc | 1;
          m = m >> 1;
        end
      end
      rom[i] = LOG_W'(acc);
    end
    return rom;
  endfunction

  // shift-and-subtract quotient, used only while building tables
  function automatic longint unsigned div_small(longint unsigned a, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((a >> b) & 64'd1);
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      x = (longint'(i) * LN2_Q30) >> LOG_TABLE_BITS;
      term = 64'd1 << 30;
      sum = term;
      for (int n = 1; n <= 24; n++) begin
        term = div_small((term * x) >> 30, longint'(n));
        sum = sum + term;
      end
      rom[i] = EXP_W'((sum + (64'd1 << 13)) >> 14);
    end
    return rom;
  endfunction

endpackage

/* sv/hdrm_if.sv */
// Stream and configuration interfaces of the HDR merge unit.
// Depends on hdrm_pkg.
interface hdrm_in_if;
  import hdrm_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel_long;
  pix_t pixel_mid;
  pix_t pixel_short;
  modport source (output valid, pixel_long, pixel_mid, pixel_short, input ready);
  modport sink   (input valid, pixel_long, pixel_mid, pixel_short, output ready);
endinterface

interface hdrm_out_if;
  import hdrm_pkg::*;
  logic valid;
  logic ready;
  pix_t merged_pixel;
  modport source (output valid, merged_pixel, input ready);
  modport sink   (input valid, merged_pixel, output ready);
endinterface

interface hdrm_cfg_if;
  import hdrm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  cfg_t                 data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

/* sv/hdr_merge_three_exposures_unit.sv */
// Top level of the three-exposure HDR merge unit: config registers and pipeline.
// Depends on hdrm_pkg, hdrm_if, hdrm_weight, hdrm_divider, hdrm_log, hdrm_exp.
//
// Fuses three aligned 8-bit exposures into one gamma-corrected pixel. One word
// enters per cycle while the output is not stalled. Each word passes through
// the stages in order: four stages build the weighted numerator, the divider's
// DIV_STAGES stages each retire four quotient bits, then three stages form log2
// times gamma and two stages the exp2 lookup and scaling. The whole pipeline
// advances together and holds while the output word waits. Write configuration
// only while the pipeline is empty.
module hdr_merge_three_exposures_unit (
  input  logic        clk,
  input  logic        rst_n,
  hdrm_in_if.sink     in_px,
  hdrm_out_if.source  out_px,
  hdrm_cfg_if.sink    cfg_wr
);
  import hdrm_pkg::*;

  cfg_t ratio_r;
  cfg_t gamma_r;
  logic en;
  logic out_valid;

  ctl_t             w_ctl, d_ctl, l_ctl;
  logic [QUO_W-1:0] w_dvd, d_quo;
  logic [DEN_W-1:0] w_den;
  logic signed [T_W-1:0] l_t;

  assign en = out_px.ready || !out_valid;
  assign in_px.ready = en;
  assign cfg_wr.ready = 1'b1;
  assign out_px.valid = out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= CFG_RESET;
      gamma_r <= CFG_RESET;
    end else if (cfg_wr.valid) begin
      if (cfg_wr.reg_index == REG_INV_RATIO) ratio_r <= cfg_wr.data;
      if (cfg_wr.reg_index == REG_GAMMA) gamma_r <= cfg_wr.data;
    end
  end

  hdrm_weight u_weight (
    .clk, .rst_n, .en,
    .in_valid (in_px.valid),
    .p0       (in_px.pixel_long),
    .p1       (in_px.pixel_mid),
    .p2       (in_px.pixel_short),
    .ratio    (ratio_r),
    .ctl_o    (w_ctl),
    .dvd_o    (w_dvd),
    .den_o    (w_den)
  );

  hdrm_divider u_div (
    .clk, .rst_n, .en,
    .ctl_i (w_ctl),
    .dvd_i (w_dvd),
    .den_i (w_den),
    .ctl_o (d_ctl),
    .quo_o (d_quo)
  );

  hdrm_log u_log (
    .clk, .rst_n, .en,
    .ctl_i (d_ctl),
    .quo_i (d_quo),
    .gamma (gamma_r),
    .ctl_o (l_ctl),
    .t_o   (l_t)
  );

  hdrm_exp u_exp (
    .clk, .rst_n, .en,
    .ctl_i   (l_ctl),
    .t_i     (l_t),
    .valid_o (out_valid),
    .pixel_o (out_px.merged_pixel)
  );

endmodule

/* sv/hdrm_weight.sv */
// Hat weights and weighted numerator, four register stages.
// Depends on hdrm_pkg.
module hdrm_weight (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  hdrm_pkg::pix_t                p0,
  input  hdrm_pkg::pix_t                p1,
  input  hdrm_pkg::pix_t                p2,
  input  hdrm_pkg::cfg_t                ratio,
  output hdrm_pkg::ctl_t                ctl_o,
  output logic [hdrm_pkg::QUO_W-1:0]    dvd_o,
  output logic [hdrm_pkg::DEN_W-1:0]    den_o
);
  import hdrm_pkg::*;

  function automatic logic [WT_W-1:0] hat(pix_t v);
    if (v < PIX_W'(128)) return (v < PIX_W'(5)) ? '0 : WT_W'(v);
    return WT_W'(PIX_W'(255) - v);
  endfunction

  logic                v1_r, v2_r, v3_r, v4_r;
  logic [PROD_W-1:0]   a0_r, a1_r, a2_r;
  logic [DEN_W-1:0]    den1_r, den2_r, den3_r, den4_r;
  logic [PROD_W-1:0]   a0_2_r, a0_3_r;
  logic [PROD_W+CFG_W-1:0] b1_r, b2_r, b1_3_r;
  logic [PROD_W+2*CFG_W-1:0] c2_r;
  logic [NUM_W-1:0]    num_r;

  logic [WT_W-1:0] w0, w1, w2;
  logic [NUM_W-1:0] num_nxt;

  always_comb begin
    w0 = hat(p0);
    w1 = hat(p1);
    w2 = hat(p2);
    if (w0 == '0 && w1 == '0 && w2 == '0) begin
      if (p1 < PIX_W'(128)) w2 = WT_W'(1);
      else w0 = WT_W'(1);
    end
    num_nxt = (NUM_W'(a0_3_r) << 24) + (NUM_W'(b1_3_r) << 12) + NUM_W'(c2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r   <= PROD_W'(w0 * p0);
      a1_r   <= PROD_W'(w1 * p1);
      a2_r   <= PROD_W'(w2 * p2);
      den1_r <= DEN_W'(w0) + DEN_W'(w1) + DEN_W'(w2);
      a0_2_r <= a0_r;
      b1_r   <= a1_r * ratio;
      b2_r   <= a2_r * ratio;
      den2_r <= den1_r;
      a0_3_r <= a0_2_r;
      b1_3_r <= b1_r;
      c2_r   <= b2_r * ratio;
      den3_r <= den2_r;
      num_r  <= num_nxt;
      den4_r <= den3_r;
    end
  end

  assign ctl_o = '{valid: v4_r, zero: (num_r == '0)};
  assign dvd_o = num_r[NUM_W-1:DIV_SHIFT];
  assign den_o = den4_r;

endmodule

/* sv/hdrm_divider.sv */
// Pipelined restoring divider, four quotient bits per stage.
// Depends on hdrm_pkg.
module hdrm_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  hdrm_pkg::ctl_t             ctl_i,
  input  logic [hdrm_pkg::QUO_W-1:0] dvd_i,
  input  logic [hdrm_pkg::DEN_W-1:0] den_i,
  output hdrm_pkg::ctl_t             ctl_o,
  output logic [hdrm_pkg::QUO_W-1:0] quo_o
);
  import hdrm_pkg::*;

  ctl_t             ctl_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [DEN_W-1:0] rem_r [DIV_STAGES];
  logic [DVD_W-1:0] dvd_r [DIV_STAGES];
  logic [DVD_W-1:0] quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    ctl_t             ctl_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_nxt;
    logic [DVD_W-1:0] dvd_nxt;
    logic [DVD_W-1:0] quo_nxt;

    if (s == 0) begin : g_first
      always_comb begin
        ctl_in = ctl_i;
        den_in = den_i;
      end
    end else begin : g_next
      always_comb begin
        ctl_in = ctl_r[s-1];
        den_in = den_r[s-1];
      end
    end

    always_comb begin
      logic [DEN_W:0] trial;
      if (s == 0) begin
        rem_nxt = '0;
        dvd_nxt = DVD_W'(dvd_i);
        quo_nxt = '0;
      end else begin
        rem_nxt = rem_r[s-1];
        dvd_nxt = dvd_r[s-1];
        quo_nxt = quo_r[s-1];
      end
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = {rem_nxt, dvd_nxt[DVD_W-1]};
        dvd_nxt = dvd_nxt << 1;
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = DEN_W'(trial - {1'b0, den_in});
          quo_nxt = {quo_nxt[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DEN_W-1:0];
          quo_nxt = {quo_nxt[DVD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].valid <= 1'b0;
      end else if (en) begin
        ctl_r[s].valid <= ctl_in.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[s].zero <= ctl_in.zero;
        den_r[s]      <= den_in;
        rem_r[s]      <= rem_nxt;
        dvd_r[s]      <= dvd_nxt;
        quo_r[s]      <= quo_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[DIV_STAGES-1];
  assign quo_o = quo_r[DIV_STAGES-1][QUO_W-1:0];

endmodule

/* sv/hdrm_log.sv */
// Log2 of the brightness and product with gamma, three register stages.
// Depends on hdrm_pkg; log2 ROM built at elaboration.
module hdrm_log (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  hdrm_pkg::ctl_t             ctl_i,
  input  logic [hdrm_pkg::QUO_W-1:0] quo_i,
  input  hdrm_pkg::cfg_t             gamma,
  output hdrm_pkg::ctl_t             ctl_o,
  output logic signed [hdrm_pkg::T_W-1:0] t_o
);
  import hdrm_pkg::*;

  localparam log_rom_t LOG_ROM = build_log_rom();

  ctl_t              ctl1_r, ctl2_r, ctl3_r;
  logic [QUO_W-1:0]  bq_r;
  logic [POS_W-1:0]  pos1_r, pos2_r;
  logic [LOG_W-1:0]  rom_r;
  logic signed [T_W-1:0] t_r;

  logic [QUO_W-1:0] bq;
  logic [POS_W-1:0] pos;
  logic [QUO_W-1:0] norm;
  logic [IDX_W-1:0] idx;
  logic signed [LG_W-1:0] lg;

  always_comb begin
    bq = (quo_i == '0) ? QUO_W'(1) : quo_i;
    pos = '0;
    for (int b = 0; b < QUO_W; b++) begin
      if (bq[b]) pos = POS_W'(b);
    end
    norm = bq_r << (POS_W'(QUO_W - 1) - pos1_r);
    idx = norm[QUO_W-2 -: IDX_W];
    lg = $signed(((LG_W'(pos2_r) - LG_W'(FRACTION_BITS)) << 16) + LG_W'(rom_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
      ctl3_r.valid <= 1'b0;
    end else if (en) begin
      ctl1_r.valid <= ctl_i.valid;
      ctl2_r.valid <= ctl1_r.valid;
      ctl3_r.valid <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r.zero <= ctl_i.zero;
      bq_r        <= bq;
      pos1_r      <= pos;
      ctl2_r.zero <= ctl1_r.zero;
      pos2_r      <= pos1_r;
      rom_r       <= LOG_ROM[idx];
      ctl3_r.zero <= ctl2_r.zero;
      t_r         <= T_W'(lg) * T_W'($signed({1'b0, gamma}));
    end
  end

  assign ctl_o = ctl3_r;
  assign t_o = t_r;

endmodule

/* sv/hdrm_exp.sv */
// Exp2 of the negated product and scaling to 8 bits, two register stages.
// Depends on hdrm_pkg; exp2 ROM built at elaboration.
module hdrm_exp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  hdrm_pkg::ctl_t                  ctl_i,
  input  logic signed [hdrm_pkg::T_W-1:0] t_i,
  output logic                            valid_o,
  output hdrm_pkg::pix_t                  pixel_o
);
  import hdrm_pkg::*;

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  ctl_t             ctl_r;
  logic             sat_r;
  logic             one_r;
  logic [SH_W-1:0]  sh_r;
  logic [EXP_W-1:0] rom_r;
  logic             out_valid_r;
  pix_t             out_pixel_r;

  logic [T_W-1:0]   mag;
  logic [15:0]      frac;
  logic [N_W-1:0]   n_int;
  logic [N_W:0]     sh_wide;
  logic [SH_W-1:0]  sh_nxt;
  logic [IDX_W-1:0] addr;
  logic [16:0]      comp;
  logic [EXP_W-1:0] mant;
  logic [EXP_W+PIX_W-1:0] prod;
  pix_t             pix_nxt;

  always_comb begin
    mag = T_W'(-t_i);
    frac = mag[27:12];
    n_int = mag[T_W-1:28];
    sh_wide = (N_W+1)'(n_int) + ((frac == '0) ? (N_W+1)'(16) : (N_W+1)'(17));
    sh_nxt = (sh_wide >= (N_W+1)'(SH_MAX)) ? SH_W'(SH_MAX) : SH_W'(sh_wide);
    comp = 17'(65536) - 17'(frac);
    addr = comp[16-LOG_TABLE_BITS +: IDX_W];
    mant = one_r ? EXP_W'(65536) : rom_r;
    prod = (EXP_W+PIX_W)'(mant) * (EXP_W+PIX_W)'(255);
    if (ctl_r.zero) pix_nxt = '0;
    else if (sat_r) pix_nxt = PIX_W'(255);
    else if (sh_r >= SH_W'(SH_MAX)) pix_nxt = '0;
    else pix_nxt = PIX_W'(prod >> sh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
      out_valid_r <= ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.zero  <= ctl_i.zero;
      sat_r       <= !t_i[T_W-1];
      one_r       <= (frac == '0);
      sh_r        <= sh_nxt;
      rom_r       <= EXP_ROM[addr];
      out_pixel_r <= pix_nxt;
    end
  end

  assign valid_o = out_valid_r;
  assign pixel_o = out_pixel_r;

  a_zero_gives_black: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ctl_r.valid && ctl_r.zero) |=> (out_pixel_r == '0))
    else $error("zero numerator did not give black");

  a_sat_gives_white: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ctl_r.valid && !ctl_r.zero && sat_r) |=> (out_pixel_r == PIX_W'(255)))
    else $error("nonnegative exponent did not saturate");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && out_valid_r) |=> (out_valid_r && $stable(out_pixel_r)))
    else $error("stalled result changed");

endmodule
